/* src/utf8esc_pkg.sv */
`default_nettype none
package utf8esc_pkg;

  localparam int unsigned CpW = 21;

  localparam logic OP_ESCAPED = 1'b0;
  localparam logic OP_RAW     = 1'b1;
  localparam logic MODE_CHAR   = 1'b0;
  localparam logic MODE_STRING = 1'b1;

  localparam logic [CpW-1:0] CP_MAX  = 21'h10FFFF;
  localparam logic [CpW-1:0] SURR_LO = 21'h00D800;
  localparam logic [CpW-1:0] SURR_HI = 21'h00DFFF;
  localparam logic [CpW-1:0] LIM1    = 21'h000080;
  localparam logic [CpW-1:0] LIM2    = 21'h000800;
  localparam logic [CpW-1:0] LIM3    = 21'h010000;
  localparam logic [CpW-1:0] DEL_CODE = 21'h00007F;
  localparam logic [CpW-1:0] C1_HI    = 21'h00009F;
  localparam logic [CpW-1:0] CTRL_LIM = 21'h000020;

  localparam logic [CpW-1:0] CP_NUL   = 21'h000000;
  localparam logic [CpW-1:0] CP_TAB   = 21'h000009;
  localparam logic [CpW-1:0] CP_LF    = 21'h00000A;
  localparam logic [CpW-1:0] CP_CR    = 21'h00000D;
  localparam logic [CpW-1:0] CP_DQUOTE = 21'h000022;
  localparam logic [CpW-1:0] CP_SQUOTE = 21'h000027;
  localparam logic [CpW-1:0] CP_BSLASH = 21'h00005C;

  localparam logic [7:0] BYTE_BSLASH = 8'h5C;
  localparam logic [7:0] BYTE_N      = 8'h6E;
  localparam logic [7:0] BYTE_T      = 8'h74;
  localparam logic [7:0] BYTE_R      = 8'h72;
  localparam logic [7:0] BYTE_ZERO   = 8'h30;
  localparam logic [7:0] BYTE_SQUOTE = 8'h27;
  localparam logic [7:0] BYTE_DQUOTE = 8'h22;

  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           operation;
    logic           escape_mode;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       rejected;
  } out_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            rejected;
  } enc_t;

endpackage
`default_nettype wire

/* src/utf8esc_decode.sv */
`default_nettype none
module utf8esc_decode (
  input  utf8esc_pkg::in_t  item_i,
  output utf8esc_pkg::enc_t enc_o
);
  import utf8esc_pkg::*;

  logic [CpW-1:0]  c;
  logic [3:0][7:0] utf;
  logic [1:0]      utf_last;
  logic [7:0]      esc;
  logic            bad_range;
  logic            bad_ctrl;

  assign c = item_i.code_point;

  always_comb begin
    utf = '0;
    if (c < LIM1) begin
      utf[0]   = c[7:0];
      utf_last = 2'd0;
    end else if (c < LIM2) begin
      utf[0]   = {LEAD2_TAG, c[10:6]};
      utf[1]   = {CONT_TAG, c[5:0]};
      utf_last = 2'd1;
    end else if (c < LIM3) begin
      utf[0]   = {LEAD3_TAG, c[15:12]};
      utf[1]   = {CONT_TAG, c[11:6]};
      utf[2]   = {CONT_TAG, c[5:0]};
      utf_last = 2'd2;
    end else begin
      utf[0]   = {LEAD4_TAG, c[20:18]};
      utf[1]   = {CONT_TAG, c[17:12]};
      utf[2]   = {CONT_TAG, c[11:6]};
      utf[3]   = {CONT_TAG, c[5:0]};
      utf_last = 2'd3;
    end
  end

  always_comb begin
    case (c)
      CP_LF:     esc = BYTE_N;
      CP_TAB:    esc = BYTE_T;
      CP_CR:     esc = BYTE_R;
      CP_NUL:    esc = BYTE_ZERO;
      CP_BSLASH: esc = BYTE_BSLASH;
      CP_SQUOTE: esc = (item_i.escape_mode == MODE_CHAR) ? BYTE_SQUOTE : 8'h00;
      CP_DQUOTE: esc = (item_i.escape_mode == MODE_STRING) ? BYTE_DQUOTE : 8'h00;
      default:   esc = 8'h00;
    endcase
  end

  assign bad_range = (c > CP_MAX) || (c inside {[SURR_LO:SURR_HI]});
  assign bad_ctrl  = (c < CTRL_LIM) || (c == DEL_CODE) || (c inside {[LIM1:C1_HI]});

  always_comb begin
    enc_o.bytes    = utf;
    enc_o.last_idx = utf_last;
    enc_o.rejected = 1'b0;
    if (item_i.operation == OP_ESCAPED) begin
      if (bad_range) begin
        enc_o.bytes    = '0;
        enc_o.last_idx = 2'd0;
        enc_o.rejected = 1'b1;
      end else if (esc != 8'h00) begin
        enc_o.bytes    = {8'h00, 8'h00, esc, BYTE_BSLASH};
        enc_o.last_idx = 2'd1;
      end else if (bad_ctrl) begin
        enc_o.bytes    = '0;
        enc_o.last_idx = 2'd0;
        enc_o.rejected = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* src/utf8_escape_encoder.sv */
// UTF-8 encoder with backslash escapes. Each input transaction carries one
// code point; the block returns 1 to 4 output transactions, one byte each,
// the final one flagged last_byte (a rejected code point gives a single
// transaction with out_byte zero and rejected set). The input is registered and
// decoded combinationally into a 4-byte result buffer; while the output is not
// stalled the buffer drains one byte per cycle and throughput is one code point
// per cycle while each yields one byte. A code point holds the output until its
// last byte is taken; input stalls once a code point waits on a busy buffer.
`default_nettype none
module utf8_escape_encoder (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  utf8esc_pkg::in_t   in_data_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output utf8esc_pkg::out_t  out_data_o
);
  import utf8esc_pkg::*;

  logic in_valid_q, in_valid_d;
  in_t  in_data_q;
  enc_t enc;

  logic            res_valid_q, res_valid_d;
  logic [3:0][7:0] bytes_q;
  logic [1:0]      last_idx_q;
  logic [1:0]      idx_q, idx_d;
  logic            rej_q;

  logic in_take;
  logic out_take;
  logic res_done;
  logic res_load;
  logic s1_free;

  utf8esc_decode u_decode (
    .item_i(in_data_q),
    .enc_o (enc)
  );

  assign out_take = out_valid_o && !out_stall_i;
  assign res_done = out_take && (idx_q == last_idx_q);
  assign res_load = in_valid_q && (!res_valid_q || res_done);
  assign s1_free  = !in_valid_q || res_load;
  assign in_stall_o = !s1_free;
  assign in_take  = in_valid_i && s1_free;

  assign in_valid_d  = in_take ? 1'b1 : (res_load ? 1'b0 : in_valid_q);
  assign res_valid_d = res_load ? 1'b1 : (res_done ? 1'b0 : res_valid_q);
  assign idx_d       = res_load ? 2'd0 : (out_take ? idx_q + 2'd1 : idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_i;
    end
    if (res_load) begin
      bytes_q    <= enc.bytes;
      last_idx_q <= enc.last_idx;
      rej_q      <= enc.rejected;
    end
  end

  assign out_valid_o          = res_valid_q;
  assign out_data_o.out_byte  = bytes_q[idx_q];
  assign out_data_o.last_byte = (idx_q == last_idx_q);
  assign out_data_o.rejected  = rej_q;

  a_reject_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rejected |->
      out_data_o.last_byte && (out_data_o.out_byte == 8'h00))
    else $error("rejected result not a single zero byte");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> idx_q <= last_idx_q)
    else $error("byte index past end of result");

  a_continue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !out_data_o.last_byte |=> out_valid_o)
    else $error("result dropped before its last byte");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && res_valid_q)
    else $error("input stalled with free stage");

endmodule
`default_nettype wire
